@@ sv/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and codes for the sorted booking table
// Field widths, opcodes, result kinds, list selectors and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package sbt_pkg;

    localparam int unsigned DAY_W   = 16;
    localparam int unsigned TAG_W   = 64;
    localparam int unsigned ENTRY_W = DAY_W + 2 * TAG_W;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_CANCEL   = 3'd1;
    localparam logic [2:0] OP_LIST_ALL = 3'd2;
    localparam logic [2:0] OP_LIST_TRP = 3'd3;
    localparam logic [2:0] OP_LIST_WTL = 3'd4;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;
    localparam logic [1:0] KIND_BADOP = 2'd3;

    localparam logic [1:0] LIST_ALL  = 2'd0;
    localparam logic [1:0] LIST_TRIP = 2'd1;
    localparam logic [1:0] LIST_WAIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_SHIFT,
        ST_CAN_SCAN,
        ST_CAN_SHIFT,
        ST_LIST,
        ST_SINGLE
    } state_t;

endpackage
`default_nettype wire

@@ sv/sorted_booking_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_booking_table_unit: sorted booking table over one entry memory
// Requests arrive on the in channel (in_valid/in_stall). Insert and cancel
// change the table and give no result; list requests give one result per
// listed entry, the final one flagged by last_of_run; an empty list, a full
// table on insert and an invalid opcode each give one marker result.
// trip_size is written over the APB port at address 0.
// One request is worked at a time. Entries live in a single-port RAM with a
// registered read, so memory touches are made one at a time: an insert scans
// forward to its place and then shifts the tail up one entry at a time
// (read, write), a cancel scans for its match and shifts the tail down the
// same way; a list reads one entry per cycle and gives one result per cycle
// while the receiver takes them.
// Results sit in an output register; out_stall holds it and pauses the
// memory read sequence. Reset empties the table (fill count zero) and
// clears trip_size; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_booking_table_unit #(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [15:0] day,
    input  wire logic [63:0] first_tag,
    input  wire logic [63:0] last_tag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [1:0]       which_list,
    output logic [15:0]      entry_day,
    output logic [63:0]      entry_first,
    output logic [63:0]      entry_last,
    output logic             last_of_run
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = sbt_pkg::ENTRY_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // config register
    logic [5:0] trip_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {26'd0, trip_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trip_reg <= 6'd0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            trip_reg <= pwdata[5:0];
    end

    sbt_pkg::state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;      // current address
    logic [CW-1:0] end_reg, end_next;      // list end
    logic          rd_reg, rd_next;        // read in flight
    logic [15:0]   day_reg;
    logic [63:0]   ft_reg, lt_reg;
    logic [1:0]    lst_reg, lst_next;
    logic [1:0]    skind_reg, skind_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;
    logic [EW-1:0] hold_reg, hold_next;    // entry carried through a shift

    sbt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [15:0] rd_day;
    logic [63:0] rd_first, rd_last;
    assign rd_day   = rdata[EW-1 -: 16];
    assign rd_first = rdata[127:64];
    assign rd_last  = rdata[63:0];

    logic accept, out_free, split_lt, ins_hit, tag_hit;
    logic [CW-1:0] split, list_start, list_end;
    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != sbt_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign split_lt = ({1'b0, trip_reg} < 7'(fill_reg));
    assign split    = split_lt ? CW'(trip_reg) : fill_reg;
    assign ins_hit  = rd_reg && (rd_day >= day_reg);
    assign tag_hit  = rd_reg && (rd_first == ft_reg) && (rd_last == lt_reg);

    // list bounds for the incoming request
    assign list_start = (opcode == sbt_pkg::OP_LIST_WTL) ? split : '0;
    assign list_end   = (opcode == sbt_pkg::OP_LIST_TRP) ? split : fill_reg;

    logic          ov_next, ov_load;
    logic [1:0]    okind_next;
    logic [EW-1:0] oent_next;
    logic          olast_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode) inside
                        sbt_pkg::OP_INSERT:
                            state_next = (fill_reg >= CAP) ? sbt_pkg::ST_SINGLE :
                                                             sbt_pkg::ST_INS_SCAN;
                        sbt_pkg::OP_CANCEL: state_next = sbt_pkg::ST_CAN_SCAN;
                        sbt_pkg::OP_LIST_ALL, sbt_pkg::OP_LIST_TRP,
                        sbt_pkg::OP_LIST_WTL:
                            state_next = (list_start >= list_end) ? sbt_pkg::ST_SINGLE :
                                                                    sbt_pkg::ST_LIST;
                        default: state_next = sbt_pkg::ST_SINGLE;
                    endcase
                end
            end
            sbt_pkg::ST_SINGLE:
            begin
                if (out_free)
                    state_next = sbt_pkg::ST_IDLE;
            end
            sbt_pkg::ST_INS_SCAN:
            begin
                if (ins_hit)
                    state_next = sbt_pkg::ST_INS_SHIFT;
                else if (idx_reg >= fill_reg)
                    state_next = sbt_pkg::ST_IDLE;
            end
            sbt_pkg::ST_INS_SHIFT:
            begin
                if (!rd_reg && idx_reg >= fill_reg)
                    state_next = sbt_pkg::ST_IDLE;
            end
            sbt_pkg::ST_CAN_SCAN:
            begin
                if (tag_hit)
                    state_next = sbt_pkg::ST_CAN_SHIFT;
                else if (idx_reg >= fill_reg)
                    state_next = sbt_pkg::ST_IDLE;
            end
            sbt_pkg::ST_CAN_SHIFT:
            begin
                if (!rd_reg && idx_reg + 1'b1 >= fill_reg)
                    state_next = sbt_pkg::ST_IDLE;
            end
            sbt_pkg::ST_LIST:
            begin
                if (rd_reg && out_free && idx_reg >= end_reg)
                    state_next = sbt_pkg::ST_IDLE;
            end
            default: state_next = sbt_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        rd_next    = 1'b0;
        lst_next   = lst_reg;
        skind_next = skind_reg;
        hold_next  = hold_reg;
        we         = 1'b0;
        addr       = idx_reg[AW-1:0];
        wdata      = hold_reg;
        ov_load    = 1'b0;
        okind_next = sbt_pkg::KIND_ENTRY;
        oent_next  = '0;
        olast_next = 1'b1;
        unique case (state_reg)
            sbt_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    unique case (opcode) inside
                        sbt_pkg::OP_INSERT:
                        begin
                            if (fill_reg >= CAP)
                            begin
                                skind_next = sbt_pkg::KIND_FULL;
                                lst_next   = sbt_pkg::LIST_ALL;
                            end
                        end
                        sbt_pkg::OP_CANCEL: idx_next = '0;
                        sbt_pkg::OP_LIST_ALL, sbt_pkg::OP_LIST_TRP,
                        sbt_pkg::OP_LIST_WTL:
                        begin
                            lst_next = (opcode == sbt_pkg::OP_LIST_ALL) ?
                                sbt_pkg::LIST_ALL : (opcode == sbt_pkg::OP_LIST_TRP) ?
                                sbt_pkg::LIST_TRIP : sbt_pkg::LIST_WAIT;
                            idx_next = list_start;
                            end_next = list_end;
                            if (list_start >= list_end)
                                skind_next = sbt_pkg::KIND_EMPTY;
                        end
                        default:
                        begin
                            skind_next = sbt_pkg::KIND_BADOP;
                            lst_next   = sbt_pkg::LIST_ALL;
                        end
                    endcase
                end
            end
            sbt_pkg::ST_SINGLE:
            begin
                if (out_free)
                begin
                    ov_load    = 1'b1;
                    okind_next = skind_reg;
                end
            end
            sbt_pkg::ST_INS_SCAN:
            begin
                // read idx, test it next cycle
                if (ins_hit)
                begin
                    // place found at idx-1: write new entry, carry old
                    we        = 1'b1;
                    addr      = AW'(idx_reg - 1'b1);
                    wdata     = {day_reg, ft_reg, lt_reg};
                    hold_next = rdata;
                end
                else if (idx_reg >= fill_reg)
                begin
                    we        = 1'b1;
                    wdata     = {day_reg, ft_reg, lt_reg};
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    rd_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sbt_pkg::ST_INS_SHIFT:
            begin
                // idx holds next slot to receive the carried entry
                if (!rd_reg)
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        we        = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                        rd_next = 1'b1;
                end
                else
                begin
                    we        = 1'b1;
                    hold_next = rdata;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            sbt_pkg::ST_CAN_SCAN:
            begin
                if (tag_hit)
                    // match at idx-1: shift tail down from idx
                    idx_next = idx_reg - 1'b1;
                else if (idx_reg < fill_reg)
                begin
                    rd_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sbt_pkg::ST_CAN_SHIFT:
            begin
                // idx is the hole; read idx+1 then write it into idx
                if (!rd_reg)
                begin
                    if (idx_reg + 1'b1 >= fill_reg)
                        fill_next = fill_reg - 1'b1;
                    else
                    begin
                        addr    = AW'(idx_reg + 1'b1);
                        rd_next = 1'b1;
                    end
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = rdata;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sbt_pkg::ST_LIST:
            begin
                // rd_reg: data for idx-1 is on rdata
                if (rd_reg && !out_free)
                begin
                    addr    = AW'(idx_reg - 1'b1);
                    rd_next = 1'b1;
                end
                else
                begin
                    if (rd_reg)
                    begin
                        ov_load    = 1'b1;
                        oent_next  = rdata;
                        olast_next = (idx_reg == end_reg);
                    end
                    if (idx_reg < end_reg)
                    begin
                        rd_next  = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: idx_next = '0;
        endcase
        ov_next = ov_load ? 1'b1 : (out_stall ? out_valid : 1'b0);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbt_pkg::ST_IDLE;
            fill_reg  <= '0;
            rd_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rd_reg    <= rd_next;
            out_valid <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        lst_reg   <= lst_next;
        skind_reg <= skind_next;
        hold_reg  <= hold_next;
        if (accept)
        begin
            day_reg <= day;
            ft_reg  <= first_tag;
            lt_reg  <= last_tag;
        end
        if (ov_load)
        begin
            kind        <= okind_next;
            which_list  <= lst_reg;
            entry_day   <= oent_next[EW-1 -: 16];
            entry_first <= oent_next[127:64];
            entry_last  <= oent_next[63:0];
            last_of_run <= olast_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/sbt_ram.sv @@
// ----------------------------------------------------------------------------
// sbt_ram: generic single-port RAM with registered read
// One address per cycle, read and write; the read is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sbt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                         wdata,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry when we is set; always read the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ sim/tb_sorted_booking_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_booking_table_unit: self-checking bench for the booking table
// Drives insert, cancel, list and invalid requests, predicts every result
// from a behavioral copy of the sorted table and compares each result in all
// its fields. Covers full-table rejects, empty lists, trip size extremes,
// random idling on both sides, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_booking_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 3 * CAP + 20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  which_list;
        logic [15:0] entry_day;
        logic [63:0] entry_first;
        logic [63:0] entry_last;
        logic        last_of_run;
    } booking_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [15:0] day = '0;
    logic [63:0] first_tag = '0;
    logic [63:0] last_tag = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  which_list;
    logic [15:0] entry_day;
    logic [63:0] entry_first;
    logic [63:0] entry_last;
    logic        last_of_run;

    // predicted table contents
    logic [15:0] tbl_day [CAP];
    logic [63:0] tbl_first [CAP];
    logic [63:0] tbl_last [CAP];
    int          tbl_fill = 0;
    int          trip_len = 0;

    booking_result_t expected_results[$];
    int  mismatch_count = 0;
    int  result_count = 0;
    int  request_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    logic [63:0] tag_pool [8];

    always #6 clk = ~clk;

    sorted_booking_table_unit #(.CAPACITY(CAP)) u_dut (.*);

    // watchdog: count cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall: random, or held for a counted hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        booking_result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, which_list, entry_day, entry_first, entry_last, last_of_run};
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    function automatic void push_marker(logic [1:0] k, logic [1:0] lst);
        expected_results.push_back('{k, lst, 16'd0, 64'd0, 64'd0, 1'b1});
    endfunction

    function automatic void predict_list_range(int from, int upto, logic [1:0] lst);
        if (from >= upto)
            push_marker(sbt_pkg::KIND_EMPTY, lst);
        else
            for (int i = from; i < upto; i++)
                expected_results.push_back('{sbt_pkg::KIND_ENTRY, lst, tbl_day[i],
                                             tbl_first[i], tbl_last[i], (i + 1 == upto)});
    endfunction

    // advance the predicted table by one request
    function automatic void predict_booking(logic [2:0] op, logic [15:0] d,
                                            logic [63:0] ft, logic [63:0] lt);
        int pos;
        int split;
        split = (trip_len < tbl_fill) ? trip_len : tbl_fill;
        case (op)
            sbt_pkg::OP_INSERT:
            begin
                if (tbl_fill >= CAP)
                    push_marker(sbt_pkg::KIND_FULL, sbt_pkg::LIST_ALL);
                else
                begin
                    pos = 0;
                    while (pos < tbl_fill && tbl_day[pos] < d)
                        pos++;
                    for (int i = tbl_fill; i > pos; i--)
                    begin
                        tbl_day[i] = tbl_day[i-1];
                        tbl_first[i] = tbl_first[i-1];
                        tbl_last[i] = tbl_last[i-1];
                    end
                    tbl_day[pos] = d;
                    tbl_first[pos] = ft;
                    tbl_last[pos] = lt;
                    tbl_fill++;
                end
            end
            sbt_pkg::OP_CANCEL:
            begin
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_first[i] == ft && tbl_last[i] == lt)
                    begin
                        for (int j = i; j + 1 < tbl_fill; j++)
                        begin
                            tbl_day[j] = tbl_day[j+1];
                            tbl_first[j] = tbl_first[j+1];
                            tbl_last[j] = tbl_last[j+1];
                        end
                        tbl_fill--;
                        break;
                    end
            end
            sbt_pkg::OP_LIST_ALL: predict_list_range(0, tbl_fill, sbt_pkg::LIST_ALL);
            sbt_pkg::OP_LIST_TRP: predict_list_range(0, split, sbt_pkg::LIST_TRIP);
            sbt_pkg::OP_LIST_WTL: predict_list_range(split, tbl_fill, sbt_pkg::LIST_WAIT);
            default: push_marker(sbt_pkg::KIND_BADOP, sbt_pkg::LIST_ALL);
        endcase
    endfunction

    // send one request; valid stays high across back-to-back requests
    task automatic send_booking(logic [2:0] op, logic [15:0] d,
                                logic [63:0] ft, logic [63:0] lt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        day <= d;
        first_tag <= ft;
        last_tag <= lt;
        predict_booking(op, d, ft, lt);
        request_count++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write trip_size while the block is idle
    task automatic write_trip_size(int value);
        go_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        trip_len = value;
    endtask

    function automatic logic [63:0] rand_tag();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_day();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    // directed: empty lists, field extremes, every opcode
    task automatic test_directed();
        send_booking(sbt_pkg::OP_LIST_ALL, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_TRP, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_WTL, 0, 0, 0);
        send_booking(sbt_pkg::OP_CANCEL, 0, 0, 0);
        send_booking(sbt_pkg::OP_INSERT, 16'hFFFF, '1, '1);
        send_booking(sbt_pkg::OP_INSERT, 16'd0, '0, '0);
        send_booking(sbt_pkg::OP_INSERT, 16'd5, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1);
        send_booking(sbt_pkg::OP_INSERT, 16'd5, 64'h2, 64'h3);
        send_booking(sbt_pkg::OP_LIST_ALL, 0, 0, 0);
        send_booking(sbt_pkg::OP_CANCEL, 0, 64'h7, 64'h7);
        send_booking(sbt_pkg::OP_CANCEL, 0, 64'h2, 64'h3);
        send_booking(sbt_pkg::OP_LIST_TRP, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_WTL, 0, 0, 0);
        send_booking(3'd5, 0, 0, 0);
        send_booking(3'd6, 16'h1234, 0, 0);
        send_booking(3'd7, 16'hFFFF, '1, '1);
    endtask

    // fill to capacity, reject an extra insert, list
    task automatic test_full_table();
        while (tbl_fill < CAP)
            send_booking(sbt_pkg::OP_INSERT, 16'($urandom_range(40)), rand_tag(),
                         rand_tag());
        send_booking(sbt_pkg::OP_INSERT, 16'd3, 64'h9, 64'h9);
        send_booking(sbt_pkg::OP_LIST_ALL, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_TRP, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_WTL, 0, 0, 0);
    endtask

    // mostly inserts and cancels of known tags, with lists and noise
    task automatic test_random(int count);
        int sel;
        logic [63:0] ft, lt;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                ft = ($urandom_range(1)) ? tag_pool[$urandom_range(7)] : rand_tag();
                lt = ($urandom_range(1)) ? tag_pool[$urandom_range(7)] : rand_tag();
                send_booking(sbt_pkg::OP_INSERT, rand_day(), ft, lt);
            end
            else if (sel < 60)
            begin
                if (tbl_fill > 0 && $urandom_range(3) != 0)
                begin
                    sel = $urandom_range(tbl_fill - 1);
                    send_booking(sbt_pkg::OP_CANCEL, 16'($urandom), tbl_first[sel],
                                 tbl_last[sel]);
                end
                else
                    send_booking(sbt_pkg::OP_CANCEL, 16'($urandom),
                                 tag_pool[$urandom_range(7)], tag_pool[$urandom_range(7)]);
            end
            else if (sel < 93)
                send_booking(3'(sbt_pkg::OP_LIST_ALL + $urandom_range(2)), 16'($urandom),
                             rand_tag(), rand_tag());
            else
                send_booking(3'($urandom_range(7, 5)), 16'($urandom), rand_tag(),
                             rand_tag());
        end
    endtask

    // stall the receiver long enough for the block to back up its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        for (int n = 0; n < 8; n++)
            send_booking(sbt_pkg::OP_LIST_ALL, 0, 0, 0);
        // pause the sender until the table has drained every result
        go_idle();
        send_booking(sbt_pkg::OP_LIST_WTL, 0, 0, 0);
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            tag_pool[i] = rand_tag();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        write_trip_size(CAP);
        test_directed();
        test_full_table();
        write_trip_size(0);
        test_full_table();
        write_trip_size(7);
        test_full_table();
        write_trip_size(63);
        send_booking(sbt_pkg::OP_LIST_TRP, 0, 0, 0);
        send_booking(sbt_pkg::OP_LIST_WTL, 0, 0, 0);
        while (tbl_fill > 0)
            send_booking(sbt_pkg::OP_CANCEL, 0, tbl_first[0], tbl_last[0]);

        write_trip_size(3);
        test_random(50);
        send_idle_pct = 77;
        write_trip_size(10);
        test_random(50);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        write_trip_size(1);
        test_random(50);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        write_trip_size($urandom_range(32));
        test_random(50);
        test_backpressure();

        go_idle();
        $display("Covered %0d requests and %0d results: inserts, cancels, lists,",
                 request_count, result_count);
        $display("full rejects, invalid opcodes, trip sizes 0 to 63 and stalls.");
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
